FILE: rtl/pscz_pkg.sv
// ----------------------------------------------------------------------------
// pscz_pkg
// shared types and codes for the pixel scale / clamp / zoom block
// ----------------------------------------------------------------------------
`default_nettype none

package pscz_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int DIM_W     = 13;
	localparam int ZOOM_W    = 6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_EN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LO  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HI  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ZOOM      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd7;

	// item opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// where a result byte comes from
	localparam logic [1:0] SRC_MAP  = 2'd0;
	localparam logic [1:0] SRC_MEM  = 2'd1;
	localparam logic [1:0] SRC_ZERO = 2'd2;

	typedef struct packed {
		logic        op;
		logic [31:0] sample;
	} pix_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       last;
		logic       row_end;
		logic       frame_end;
		logic       replay_pending;
		logic       dropped;
	} res_t;

	// per-item control that travels down the pipe
	typedef struct packed {
		logic [1:0] src;
		logic       wr;
		logic       row_end;
		logic       frame_end;
		logic       pend;
		logic       drop;
	} ctl_t;

endpackage

`default_nettype wire

FILE: rtl/pixel_scale_clamp_zoom.sv
// ----------------------------------------------------------------------------
// pixel_scale_clamp_zoom
// signed Q15.16 pixels to display bytes with clamp and nearest-neighbor zoom
// ----------------------------------------------------------------------------
// Each pixel item is mapped as sample*scale+offset, truncated toward zero,
// low byte kept, then optionally clamped. Zoom -1..1 passes every pixel, a
// positive zoom k keeps every k-th pixel of every k-th row, a negative zoom
// repeats each pixel |k| times and saves the row in a line store; later tick
// items replay that row |k|-1 times. An item is accepted every cycle while
// the output keeps up; an item with k copies holds the output register until
// all k copies have gone out. Mapping runs through four stages (register,
// multiply, add and truncate, clamp into the output register). A tick that
// starts a replay waits until the row's last line store write has left the
// pipe, and longer while copies ahead of that pixel still hold the output
// register. The line store needs no clearing pass after reset.
`default_nettype none

module pixel_scale_clamp_zoom #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	parameter int MAX_ZOOM   = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// pixel / tick items in
	input  wire logic                             pix_valid,
	output logic                                  pix_stall,
	input  wire pscz_pkg::pix_t                   pix,
	// result items out
	output logic                                  res_valid,
	input  wire logic                             res_stall,
	output pscz_pkg::res_t                        res,
	// register writes
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [pscz_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                      cfg_data
);
	import pscz_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int KW = $clog2(MAX_ZOOM + 1);

	// configuration registers
	logic [31:0]       scale_q, offset_q;
	logic              clamp_en_q;
	logic [7:0]        clamp_lo_q, clamp_hi_q;
	logic [ZOOM_W-1:0] zoom_q;
	logic [DIM_W-1:0]  width_q, height_q;

	// control to pipe
	ctl_t          ctl0, ctl3;
	logic          emit0, rd_en, tick_live, acc, adv, wr_busy, v3, we;
	logic [KW-1:0] cnt0, cnt3;
	logic [CW-1:0] addr0, waddr;
	logic [7:0]    rdata, byte3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= 32'h0001_0000;
			offset_q   <= '0;
			clamp_en_q <= 1'b0;
			clamp_lo_q <= 8'h80;
			clamp_hi_q <= 8'h7f;
			zoom_q     <= ZOOM_W'(1);
			width_q    <= DIM_W'(4096);
			height_q   <= DIM_W'(4096);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SCALE:    scale_q    <= cfg_data;
				REG_OFFSET:   offset_q   <= cfg_data;
				REG_CLAMP_EN: clamp_en_q <= cfg_data[0];
				REG_CLAMP_LO: clamp_lo_q <= cfg_data[7:0];
				REG_CLAMP_HI: clamp_hi_q <= cfg_data[7:0];
				REG_ZOOM:     zoom_q     <= cfg_data[ZOOM_W-1:0];
				REG_WIDTH:    width_q    <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:   height_q   <= cfg_data[DIM_W-1:0];
				default:      ;
			endcase
		end
	end

	// whole pipe moves together when the output register frees up;
	// a replay tick also waits for pending line store writes
	assign pix_stall = !adv || (tick_live && wr_busy);
	assign acc       = pix_valid && !pix_stall;

	pscz_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_ZOOM   (MAX_ZOOM),
		.CW         (CW),
		.KW         (KW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.op        (pix.op),
		.zoom      (zoom_q),
		.width     (width_q),
		.height    (height_q),
		.ctl       (ctl0),
		.emit      (emit0),
		.cnt       (cnt0),
		.addr      (addr0),
		.rd_en     (rd_en),
		.tick_live (tick_live)
	);

	pscz_lstore #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_lstore (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (byte3),
		.re    (rd_en),
		.raddr (addr0),
		.rdata (rdata)
	);

	pscz_map #(
		.CW (CW),
		.KW (KW)
	) u_map (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.v_in         (acc && emit0),
		.ctl_in       (ctl0),
		.cnt_in       (cnt0),
		.addr_in      (addr0),
		.sample       (pix.sample),
		.scale        (scale_q),
		.offset_value (offset_q),
		.clamp_enable (clamp_en_q),
		.clamp_low    (clamp_lo_q),
		.clamp_high   (clamp_hi_q),
		.rdata        (rdata),
		.v_out        (v3),
		.ctl_out      (ctl3),
		.cnt_out      (cnt3),
		.byte_out     (byte3),
		.we           (we),
		.waddr        (waddr),
		.wr_busy      (wr_busy)
	);

	pscz_emit #(
		.KW (KW)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_in      (v3),
		.ctl_in    (ctl3),
		.cnt_in    (cnt3),
		.byte_in   (byte3),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res),
		.adv       (adv)
	);

endmodule

`default_nettype wire

FILE: rtl/pscz_lstore.sv
// ----------------------------------------------------------------------------
// pscz_lstore
// line store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pscz_lstore #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pscz_ctrl.sv
// ----------------------------------------------------------------------------
// pscz_ctrl
// position counters, replay sequencing and per-item decisions
// ----------------------------------------------------------------------------
`default_nettype none

module pscz_ctrl #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	parameter int MAX_ZOOM   = 16,
	parameter int CW         = 12,
	parameter int KW         = 5
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         acc,
	input  wire logic                         op,
	input  wire logic [pscz_pkg::ZOOM_W-1:0]  zoom,
	input  wire logic [pscz_pkg::DIM_W-1:0]   width,
	input  wire logic [pscz_pkg::DIM_W-1:0]   height,
	output pscz_pkg::ctl_t                    ctl,
	output logic                              emit,
	output logic [KW-1:0]                     cnt,
	output logic [CW-1:0]                     addr,
	output logic                              rd_en,
	output logic                              tick_live
);
	import pscz_pkg::*;

	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int EW  = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
	localparam int EHW = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;
	localparam int PW  = $clog2(MAX_ZOOM);

	logic [CW-1:0] col_q, rcol_q;
	logic [RW-1:0] row_q;
	logic [PW-1:0] pass_q;
	logic [KW-1:0] cph_q [2:MAX_ZOOM];
	logic [KW-1:0] rph_q [2:MAX_ZOOM];

	logic signed [7:0] z8;
	logic [7:0]        mag8;
	logic              repl, decim;
	logic [KW-1:0]     k, kd;
	logic [EW-1:0]     w_ext, w_eff;
	logic [EHW-1:0]    h_ext, h_eff;
	logic              rowdone, framedone, rend, hit, dec_re, dec_fe, pass_one;
	logic              pix_ok, next_row;

	always_comb begin
		z8    = {{(8-ZOOM_W){zoom[ZOOM_W-1]}}, zoom};
		repl  = z8 < -8'sd1;
		decim = z8 > 8'sd1;
		mag8  = repl ? 8'(-z8) : 8'(z8);
		if (repl || decim) begin
			k = (mag8 > 8'(MAX_ZOOM)) ? KW'(MAX_ZOOM) : KW'(mag8);
		end else begin
			k = KW'(1);
		end
		kd = decim ? k : KW'(2);

		w_ext = EW'(width);
		if (w_ext == '0) w_eff = EW'(1);
		else if (w_ext > EW'(MAX_WIDTH)) w_eff = EW'(MAX_WIDTH);
		else w_eff = w_ext;
		h_ext = EHW'(height);
		if (h_ext == '0) h_eff = EHW'(1);
		else if (h_ext > EHW'(MAX_HEIGHT)) h_eff = EHW'(MAX_HEIGHT);
		else h_eff = h_ext;

		rowdone   = EW'(col_q) >= w_eff - EW'(1);
		framedone = EHW'(row_q) >= h_eff - EHW'(1);
		rend      = EW'(rcol_q) >= w_eff - EW'(1);
		hit       = (cph_q[kd] == '0) && (rph_q[kd] == '0);
		dec_re    = (EW+1)'(col_q) + (EW+1)'(k) >= (EW+1)'(w_eff);
		dec_fe    = (EHW+1)'(row_q) + (EHW+1)'(k) >= (EHW+1)'(h_eff);
		pass_one  = pass_q == PW'(1);

		tick_live = (op == OP_TICK) && (pass_q != '0);
		pix_ok    = (op == OP_PIXEL) && (pass_q == '0);
		rd_en     = acc && tick_live;
		addr      = (op == OP_TICK) ? rcol_q : col_q;

		ctl  = '0;
		emit = 1'b0;
		cnt  = KW'(1);
		if (op == OP_PIXEL) begin
			if (pass_q != '0) begin
				// pixel during replay: discarded, flagged
				emit     = 1'b1;
				ctl.src  = SRC_ZERO;
				ctl.drop = 1'b1;
				ctl.pend = 1'b1;
			end else begin
				ctl.src = SRC_MAP;
				if (repl) begin
					emit        = 1'b1;
					cnt         = k;
					ctl.wr      = 1'b1;
					ctl.row_end = rowdone;
					ctl.pend    = rowdone;
				end else if (decim) begin
					emit          = hit;
					ctl.row_end   = dec_re;
					ctl.frame_end = dec_re && dec_fe;
				end else begin
					emit          = 1'b1;
					ctl.row_end   = rowdone;
					ctl.frame_end = rowdone && framedone;
				end
			end
		end else begin
			emit          = pass_q != '0;
			cnt           = repl ? k : KW'(1);
			ctl.src       = SRC_MEM;
			ctl.row_end   = rend;
			ctl.frame_end = rend && pass_one && framedone;
			ctl.pend      = !(rend && pass_one);
		end

		next_row = acc && ((pix_ok && rowdone && !repl) ||
			(tick_live && rend && pass_one));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			rcol_q <= '0;
			row_q  <= '0;
			pass_q <= '0;
			for (int j = 2; j <= MAX_ZOOM; j++) begin
				cph_q[j] <= '0;
				rph_q[j] <= '0;
			end
		end else begin
			if (acc && pix_ok) begin
				if (rowdone) begin
					col_q <= '0;
					for (int j = 2; j <= MAX_ZOOM; j++) cph_q[j] <= '0;
					if (repl) begin
						pass_q <= PW'(k - KW'(1));
						rcol_q <= '0;
					end
				end else begin
					col_q <= col_q + CW'(1);
					for (int j = 2; j <= MAX_ZOOM; j++) begin
						cph_q[j] <= (cph_q[j] == KW'(j - 1)) ? '0 : cph_q[j] + KW'(1);
					end
				end
			end
			if (acc && tick_live) begin
				if (rend) begin
					rcol_q <= '0;
					pass_q <= pass_q - PW'(1);
				end else begin
					rcol_q <= rcol_q + CW'(1);
				end
			end
			if (next_row) begin
				if (framedone) begin
					row_q <= '0;
					for (int j = 2; j <= MAX_ZOOM; j++) rph_q[j] <= '0;
				end else begin
					row_q <= row_q + RW'(1);
					for (int j = 2; j <= MAX_ZOOM; j++) begin
						rph_q[j] <= (rph_q[j] == KW'(j - 1)) ? '0 : rph_q[j] + KW'(1);
					end
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_pass_range: assert property (@(posedge clk) disable iff (!arst_n)
		pass_q <= PW'(MAX_ZOOM - 1))
		else $error("replay pass count out of range");
	a_rcol_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pass_q == '0) |-> (rcol_q == '0))
		else $error("replay column moved with no replay pending");
	a_drop_one: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == OP_PIXEL && pass_q != '0) |=> $stable(col_q) && $stable(pass_q))
		else $error("discarded pixel changed position state");
`endif

endmodule

`default_nettype wire

FILE: rtl/pscz_map.sv
// ----------------------------------------------------------------------------
// pscz_map
// intensity mapping pipe: multiply, add and truncate, clamp
// ----------------------------------------------------------------------------
`default_nettype none

module pscz_map #(
	parameter int CW = 12,
	parameter int KW = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              v_in,
	input  wire pscz_pkg::ctl_t    ctl_in,
	input  wire logic [KW-1:0]     cnt_in,
	input  wire logic [CW-1:0]     addr_in,
	input  wire logic [31:0]       sample,
	input  wire logic [31:0]       scale,
	input  wire logic [31:0]       offset_value,
	input  wire logic              clamp_enable,
	input  wire logic [7:0]        clamp_low,
	input  wire logic [7:0]        clamp_high,
	input  wire logic [7:0]        rdata,
	output logic                   v_out,
	output pscz_pkg::ctl_t         ctl_out,
	output logic [KW-1:0]          cnt_out,
	output logic [7:0]             byte_out,
	output logic                   we,
	output logic [CW-1:0]          waddr,
	output logic                   wr_busy
);
	import pscz_pkg::*;

	logic                v_s1, v_s2, v_s3;
	ctl_t                ctl_s1, ctl_s2, ctl_s3;
	logic [KW-1:0]       cnt_s1, cnt_s2, cnt_s3;
	logic [CW-1:0]       addr_s1, addr_s2, addr_s3;
	logic signed [31:0]  smp_s1;
	logic signed [63:0]  prod_s2;
	logic [7:0]          mb_s2, mb_s3, hi_s3;
	logic                inc_s3;

	logic signed [63:0]  total;
	logic [7:0]          raw;
	logic signed [7:0]   cv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		total = prod_s2 + {{16{offset_value[31]}}, offset_value, 16'b0};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1  <= ctl_in;
			cnt_s1  <= cnt_in;
			addr_s1 <= addr_in;
			smp_s1  <= sample;
			ctl_s2  <= ctl_s1;
			cnt_s2  <= cnt_s1;
			addr_s2 <= addr_s1;
			prod_s2 <= smp_s1 * $signed(scale);
			mb_s2   <= rdata;
			ctl_s3  <= ctl_s2;
			cnt_s3  <= cnt_s2;
			addr_s3 <= addr_s2;
			mb_s3   <= mb_s2;
			hi_s3   <= total[39:32];
			// truncation toward zero: bump negatives with a fraction
			inc_s3  <= total[63] && (total[31:0] != '0);
		end
	end

	always_comb begin
		raw = hi_s3 + {7'b0, inc_s3};
		cv  = $signed(raw);
		if (clamp_enable) begin
			if (cv < $signed(clamp_low)) cv = $signed(clamp_low);
			if (cv > $signed(clamp_high)) cv = $signed(clamp_high);
		end
		unique case (ctl_s3.src)
			SRC_MAP:  byte_out = 8'(cv);
			SRC_MEM:  byte_out = mb_s3;
			default:  byte_out = 8'h00;
		endcase
		v_out   = v_s3;
		ctl_out = ctl_s3;
		cnt_out = cnt_s3;
		we      = adv && v_s3 && ctl_s3.wr;
		waddr   = addr_s3;
		wr_busy = (v_s1 && ctl_s1.wr) || (v_s2 && ctl_s2.wr) || (v_s3 && ctl_s3.wr);
	end

`ifndef SYNTHESIS
	a_wr_src: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && ctl_s3.wr) |-> (ctl_s3.src == SRC_MAP))
		else $error("line store write from a non-mapped byte");
	a_mem_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && ctl_s1.src == SRC_MEM) |-> !(v_s2 && ctl_s2.wr) && !(v_s3 && ctl_s3.wr))
		else $error("replay read overlapped a pending line store write");
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && ctl_s3.drop) |-> (byte_out == 8'h00))
		else $error("discarded pixel carried data");
`endif

endmodule

`default_nettype wire

FILE: rtl/pscz_emit.sv
// ----------------------------------------------------------------------------
// pscz_emit
// output register, repeats one byte for each copy of the item
// ----------------------------------------------------------------------------
`default_nettype none

module pscz_emit #(
	parameter int KW = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          v_in,
	input  wire pscz_pkg::ctl_t ctl_in,
	input  wire logic [KW-1:0] cnt_in,
	input  wire logic [7:0]    byte_in,
	input  wire logic          res_stall,
	output logic               res_valid,
	output pscz_pkg::res_t     res,
	output logic               adv
);
	import pscz_pkg::*;

	logic          v_s4;
	ctl_t          ctl_s4;
	logic [KW-1:0] rem_s4;
	logic [7:0]    byte_s4;
	logic          lastc;

	always_comb begin
		lastc              = rem_s4 == KW'(1);
		adv                = !v_s4 || (!res_stall && lastc);
		res_valid          = v_s4;
		res.pixel          = byte_s4;
		res.last           = lastc;
		res.row_end        = ctl_s4.row_end && lastc;
		res.frame_end      = ctl_s4.frame_end && lastc;
		res.replay_pending = ctl_s4.pend;
		res.dropped        = ctl_s4.drop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4   <= 1'b0;
			rem_s4 <= '0;
		end else if (adv) begin
			v_s4   <= v_in;
			rem_s4 <= v_in ? cnt_in : '0;
		end else if (!res_stall) begin
			rem_s4 <= rem_s4 - KW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4  <= ctl_in;
			byte_s4 <= byte_in;
		end
	end

`ifndef SYNTHESIS
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (rem_s4 != '0))
		else $error("output item with no copies left");
	a_drop_single: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && ctl_s4.drop) |-> (ctl_s4.pend && lastc))
		else $error("discard result not single or not pending");
	a_fe_re: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && ctl_s4.frame_end) |-> ctl_s4.row_end)
		else $error("frame end without row end");
`endif

endmodule

`default_nettype wire
